### rtl/cdc_pkg.sv
// Shared types, codes and calendar helpers for the date-time counter.
// No dependencies; imported by calendar_datetime_counter_top.
`timescale 1ns / 1ps

package cdc_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned CountW = 16;

  localparam logic [31:0]      MAX_STEPS_DEF = 32'd65535;
  localparam logic [YearW-1:0] YEAR_MAX_DEF  = 14'd9999;

  // Reciprocal of 100 for a 14-bit year: q = (y * 5243) >> 19 is exact here.
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam int unsigned Recip100Sh = 19;
  localparam int unsigned QuotW      = 8;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_FWD  = 2'd1,
    ACT_BACK = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_DATE = 2'd1,
    STATUS_BAD_TIME = 2'd2,
    STATUS_LIMIT    = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOAD_Q = 5'b00010,
    ST_LOAD_C = 5'b00100,
    ST_STEP   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  // Month length; out-of-range months read as 31.
  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] month,
                                              input logic leap);
    logic [DayW-1:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Leap rule from the year and its registered quotient by 100.
  function automatic logic is_leap(input logic [YearW-1:0] year,
                                   input logic [QuotW-1:0] quot);
    logic [YearW-1:0] hund;
    hund = YearW'({quot, 6'b0}) + YearW'({quot, 5'b0}) + YearW'({quot, 2'b0});
    return (year[1:0] == 2'b00) && ((year != hund) || (quot[1:0] == 2'b00));
  endfunction

endpackage

### rtl/calendar_datetime_counter_top.sv
// Gregorian date and time-of-day counter with load, step-forward and step-back.
// Depends on cdc_pkg for codes, month lengths and the leap rule.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_stall_o   action, count, set_* date-time
//   out      source     out_valid_o/out_stall_i cur_* date-time, status
//
// A load passes from the input beat through LOAD_Q and LOAD_C to DONE and
// then to the result register; a step applies min(count, MAX_STEPS) one-second
// ticks of the shared tick unit, one per cycle, fewer if the year limit stops it.
// Reset sets 0001-01-01 00:00:00. Input is stalled while an item is in work;
// a finished result waits in the result register, and the next item is taken
// as soon as the result has been handed over to that register.
`timescale 1ns / 1ps

module calendar_datetime_counter_top #(
  parameter logic [31:0]                MAX_STEPS = cdc_pkg::MAX_STEPS_DEF,
  parameter logic [cdc_pkg::YearW-1:0]  YEAR_MAX  = cdc_pkg::YEAR_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [cdc_pkg::CountW-1:0]    count_i,
  input  logic [cdc_pkg::YearW-1:0]     set_year_i,
  input  logic [cdc_pkg::MonthW-1:0]    set_month_i,
  input  logic [cdc_pkg::DayW-1:0]      set_day_i,
  input  logic [cdc_pkg::HourW-1:0]     set_hour_i,
  input  logic [cdc_pkg::MinW-1:0]      set_minute_i,
  input  logic [cdc_pkg::SecW-1:0]      set_second_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cdc_pkg::YearW-1:0]     cur_year_o,
  output logic [cdc_pkg::MonthW-1:0]    cur_month_o,
  output logic [cdc_pkg::DayW-1:0]      cur_day_o,
  output logic [cdc_pkg::HourW-1:0]     cur_hour_o,
  output logic [cdc_pkg::MinW-1:0]      cur_minute_o,
  output logic [cdc_pkg::SecW-1:0]      cur_second_o,
  output logic [1:0]                    status_o
);

  import cdc_pkg::*;

  state_e state_q, state_d;

  logic [YearW-1:0]  year_q, year_d;
  logic [MonthW-1:0] month_q, month_d;
  logic [DayW-1:0]   day_q, day_d;
  logic [HourW-1:0]  hour_q, hour_d;
  logic [MinW-1:0]   min_q, min_d;
  logic [SecW-1:0]   sec_q, sec_d;

  logic [1:0]        act_q;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [YearW-1:0]  sy_q;
  logic [MonthW-1:0] sm_q;
  logic [DayW-1:0]   sd_q;
  logic [HourW-1:0]  sh_q;
  logic [MinW-1:0]   smi_q;
  logic [SecW-1:0]   ss_q;

  logic [1:0]        stat_q, stat_d;
  logic [QuotW-1:0]  quot_q;

  logic              out_valid_q;
  logic [YearW-1:0]  oy_q;
  logic [MonthW-1:0] om_q;
  logic [DayW-1:0]   od_q;
  logic [HourW-1:0]  oh_q;
  logic [MinW-1:0]   omi_q;
  logic [SecW-1:0]   os_q;
  logic [1:0]        ost_q;

  logic in_beat, out_free, res_load;
  logic [CountW-1:0] cnt_clamped;

  // Shared reciprocal multiplier: the load year while checking, else the held year.
  logic [YearW-1:0]    mul_a;
  logic [YearW+12:0]   mul_p;
  logic                leap_cur;

  // Tick unit results.
  logic [YearW-1:0]  t_year;
  logic [MonthW-1:0] t_month;
  logic [DayW-1:0]   t_day;
  logic [HourW-1:0]  t_hour;
  logic [MinW-1:0]   t_min;
  logic [SecW-1:0]   t_sec;
  logic              t_block;
  logic [DayW-1:0]   dim_cur, dim_prev;
  logic [MonthW-1:0] month_prev;

  logic date_ok, time_ok;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_beat    = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign res_load   = (state_q == ST_DONE) && out_free;

  assign cnt_clamped = ({16'b0, count_i} > MAX_STEPS) ? MAX_STEPS[CountW-1:0] : count_i;

  assign mul_a    = (state_q == ST_LOAD_Q) ? sy_q : year_q;
  assign mul_p    = mul_a * Recip100;
  assign leap_cur = is_leap(year_q, quot_q);

  assign dim_cur    = days_in(month_q, leap_cur);
  assign month_prev = month_q - 4'd1;
  assign dim_prev   = days_in(month_prev, leap_cur);

  always_comb begin
    t_year  = year_q;
    t_month = month_q;
    t_day   = day_q;
    t_hour  = hour_q;
    t_min   = min_q;
    t_sec   = sec_q;
    t_block = 1'b0;
    if (act_q == ACT_FWD) begin
      if (sec_q < 6'd59) begin
        t_sec = sec_q + 6'd1;
      end else if (min_q < 6'd59) begin
        t_min = min_q + 6'd1;
        t_sec = '0;
      end else if (hour_q < 5'd23) begin
        t_hour = hour_q + 5'd1;
        t_min  = '0;
        t_sec  = '0;
      end else if ((day_q >= dim_cur) && (month_q >= 4'd12) && (year_q >= YEAR_MAX)) begin
        t_block = 1'b1;
      end else begin
        t_hour = '0;
        t_min  = '0;
        t_sec  = '0;
        if (day_q >= dim_cur) begin
          t_day = 5'd1;
          if (month_q >= 4'd12) begin
            t_year  = year_q + 14'd1;
            t_month = 4'd1;
          end else begin
            t_month = month_q + 4'd1;
          end
        end else begin
          t_day = day_q + 5'd1;
        end
      end
    end else begin
      if (sec_q > 6'd0) begin
        t_sec = sec_q - 6'd1;
      end else if (min_q > 6'd0) begin
        t_min = min_q - 6'd1;
        t_sec = 6'd59;
      end else if (hour_q > 5'd0) begin
        t_hour = hour_q - 5'd1;
        t_min  = 6'd59;
        t_sec  = 6'd59;
      end else if ((day_q <= 5'd1) && (month_q <= 4'd1) && (year_q <= 14'd1)) begin
        t_block = 1'b1;
      end else begin
        t_hour = 5'd23;
        t_min  = 6'd59;
        t_sec  = 6'd59;
        if (day_q <= 5'd1) begin
          if (month_q <= 4'd1) begin
            t_year  = year_q - 14'd1;
            t_month = 4'd12;
            t_day   = 5'd31;
          end else begin
            t_month = month_prev;
            t_day   = dim_prev;
          end
        end else begin
          t_day = day_q - 5'd1;
        end
      end
    end
  end

  assign date_ok = (sm_q >= 4'd1) && (sm_q <= 4'd12) && (sy_q >= 14'd1) && (sy_q <= YEAR_MAX)
                && (sd_q >= 5'd1) && (sd_q <= days_in(sm_q, is_leap(sy_q, quot_q)));
  assign time_ok = (sh_q <= 5'd23) && (smi_q <= 6'd59) && (ss_q <= 6'd59);

  always_comb begin
    state_d = state_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    cnt_d   = cnt_q;
    stat_d  = stat_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d  = cnt_clamped;
          stat_d = STATUS_OK;
          if (action_i == ACT_LOAD) begin
            state_d = ST_LOAD_Q;
          end else if ((action_i == ACT_FWD) || (action_i == ACT_BACK)) begin
            state_d = ST_STEP;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_LOAD_Q: state_d = ST_LOAD_C;
      ST_LOAD_C: begin
        state_d = ST_DONE;
        if (!date_ok) begin
          stat_d = STATUS_BAD_DATE;
        end else if (!time_ok) begin
          stat_d = STATUS_BAD_TIME;
        end else begin
          year_d  = sy_q;
          month_d = sm_q;
          day_d   = sd_q;
          hour_d  = sh_q;
          min_d   = smi_q;
          sec_d   = ss_q;
        end
      end
      ST_STEP: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else if (t_block) begin
          // drop the remaining ticks at the year limit
          stat_d  = STATUS_LIMIT;
          state_d = ST_DONE;
        end else begin
          year_d  = t_year;
          month_d = t_month;
          day_d   = t_day;
          hour_d  = t_hour;
          min_d   = t_min;
          sec_d   = t_sec;
          cnt_d   = cnt_q - 16'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      year_q      <= 14'd1;
      month_q     <= 4'd1;
      day_q       <= 5'd1;
      hour_q      <= '0;
      min_q       <= '0;
      sec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      hour_q  <= hour_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    quot_q <= mul_p[Recip100Sh +: QuotW];
    cnt_q  <= cnt_d;
    stat_q <= stat_d;
    if (in_beat) begin
      act_q <= action_i;
      sy_q  <= set_year_i;
      sm_q  <= set_month_i;
      sd_q  <= set_day_i;
      sh_q  <= set_hour_i;
      smi_q <= set_minute_i;
      ss_q  <= set_second_i;
    end
    if (res_load) begin
      oy_q  <= year_q;
      om_q  <= month_q;
      od_q  <= day_q;
      oh_q  <= hour_q;
      omi_q <= min_q;
      os_q  <= sec_q;
      ost_q <= stat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cur_year_o   = oy_q;
  assign cur_month_o  = om_q;
  assign cur_day_o    = od_q;
  assign cur_hour_o   = oh_q;
  assign cur_minute_o = omi_q;
  assign cur_second_o = os_q;
  assign status_o     = ost_q;

endmodule

### bench/tb_calendar_datetime_counter_top.sv
// Self-checking bench for calendar_datetime_counter_top: loads, second steps, year limits.
// Beats are queued up front, driven in random bursts and checked against a calendar predictor.
// Depends on cdc_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_calendar_datetime_counter_top;
  import cdc_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int YEAR_LAST = int'(YEAR_MAX_DEF);
  localparam int BIG_STEPS_MAX = 4;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
  } stamp_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [CountW-1:0] count;
    stamp_t            set;
  } beat_t;

  typedef struct packed {
    stamp_t  now;
    status_e status;
  } reading_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PULSE
  } stall_style_e;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [1:0]        action_i     = '0;
  logic [CountW-1:0] count_i      = '0;
  logic [YearW-1:0]  set_year_i   = '0;
  logic [MonthW-1:0] set_month_i  = '0;
  logic [DayW-1:0]   set_day_i    = '0;
  logic [HourW-1:0]  set_hour_i   = '0;
  logic [MinW-1:0]   set_minute_i = '0;
  logic [SecW-1:0]   set_second_i = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [YearW-1:0]  cur_year_o;
  logic [MonthW-1:0] cur_month_o;
  logic [DayW-1:0]   cur_day_o;
  logic [HourW-1:0]  cur_hour_o;
  logic [MinW-1:0]   cur_minute_o;
  logic [SecW-1:0]   cur_second_o;
  logic [1:0]        status_o;

  calendar_datetime_counter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .count_i      (count_i),
    .set_year_i   (set_year_i),
    .set_month_i  (set_month_i),
    .set_day_i    (set_day_i),
    .set_hour_i   (set_hour_i),
    .set_minute_i (set_minute_i),
    .set_second_i (set_second_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cur_year_o   (cur_year_o),
    .cur_month_o  (cur_month_o),
    .cur_day_o    (cur_day_o),
    .cur_hour_o   (cur_hour_o),
    .cur_minute_o (cur_minute_o),
    .cur_second_o (cur_second_o),
    .status_o     (status_o)
  );

  beat_t    pending_beats[$];
  reading_t expected_readings[$];
  stamp_t   model_now;
  beat_t    drive_beat;

  int mismatches   = 0;
  int big_left     = BIG_STEPS_MAX;
  int n_checked    = 0;
  int n_loads      = 0;
  int n_rejects    = 0;
  int n_fwd        = 0;
  int n_back       = 0;
  int n_limit      = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------- calendar predictor ----------------

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_len(input int y, input int m);
    case (m)
      2:              return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  function automatic bit tick_forward();
    if (model_now.second < 59) begin
      model_now.second = model_now.second + 1'b1;
      return 1'b1;
    end
    if (model_now.minute < 59) begin
      model_now.minute = model_now.minute + 1'b1;
      model_now.second = '0;
      return 1'b1;
    end
    if (model_now.hour < 23) begin
      model_now.hour   = model_now.hour + 1'b1;
      model_now.minute = '0;
      model_now.second = '0;
      return 1'b1;
    end
    if (model_now.day >= month_len(model_now.year, model_now.month)) begin
      if (model_now.month >= 12) begin
        // hold at the last second of the last year
        if (model_now.year >= YEAR_LAST) return 1'b0;
        model_now.year  = model_now.year + 1'b1;
        model_now.month = 4'd1;
      end else begin
        model_now.month = model_now.month + 1'b1;
      end
      model_now.day = 5'd1;
    end else begin
      model_now.day = model_now.day + 1'b1;
    end
    model_now.hour   = '0;
    model_now.minute = '0;
    model_now.second = '0;
    return 1'b1;
  endfunction

  function automatic bit tick_back();
    if (model_now.second > 0) begin
      model_now.second = model_now.second - 1'b1;
      return 1'b1;
    end
    if (model_now.minute > 0) begin
      model_now.minute = model_now.minute - 1'b1;
      model_now.second = 6'd59;
      return 1'b1;
    end
    if (model_now.hour > 0) begin
      model_now.hour   = model_now.hour - 1'b1;
      model_now.minute = 6'd59;
      model_now.second = 6'd59;
      return 1'b1;
    end
    if (model_now.day <= 1) begin
      if (model_now.month <= 1) begin
        if (model_now.year <= 1) return 1'b0;
        model_now.year  = model_now.year - 1'b1;
        model_now.month = 4'd12;
        model_now.day   = 5'd31;
      end else begin
        model_now.month = model_now.month - 1'b1;
        model_now.day   = DayW'(month_len(model_now.year, model_now.month));
      end
    end else begin
      model_now.day = model_now.day - 1'b1;
    end
    model_now.hour   = 5'd23;
    model_now.minute = 6'd59;
    model_now.second = 6'd59;
    return 1'b1;
  endfunction

  function automatic reading_t apply_beat(input beat_t b);
    reading_t r;
    status_e  st;
    bit       moved;
    st = STATUS_OK;
    if (b.action == ACT_LOAD) begin
      n_loads++;
      // date is judged before time
      if (b.set.month < 1 || b.set.month > 12 || b.set.year < 1 || b.set.year > YEAR_LAST ||
          b.set.day < 1 || b.set.day > month_len(b.set.year, b.set.month)) begin
        st = STATUS_BAD_DATE;
      end else if (b.set.hour > 23 || b.set.minute > 59 || b.set.second > 59) begin
        st = STATUS_BAD_TIME;
      end else begin
        model_now = b.set;
      end
      if (st != STATUS_OK) n_rejects++;
    end else if (b.action == ACT_FWD || b.action == ACT_BACK) begin
      if (b.action == ACT_FWD) n_fwd++;
      else n_back++;
      for (int k = 0; k < int'(b.count); k++) begin
        moved = (b.action == ACT_FWD) ? tick_forward() : tick_back();
        if (!moved) begin
          // drop the remaining steps
          st = STATUS_LIMIT;
          n_limit++;
          break;
        end
      end
    end
    r.now    = model_now;
    r.status = st;
    return r;
  endfunction

  // ---------------- stimulus construction ----------------

  function automatic beat_t load_beat(input int y, input int m, input int d,
                                      input int h, input int mi, input int s);
    beat_t b;
    b.action     = ACT_LOAD;
    b.count      = CountW'($urandom);
    b.set.year   = YearW'(y);
    b.set.month  = MonthW'(m);
    b.set.day    = DayW'(d);
    b.set.hour   = HourW'(h);
    b.set.minute = MinW'(mi);
    b.set.second = SecW'(s);
    return b;
  endfunction

  function automatic beat_t step_beat(input logic [1:0] act, input int n);
    beat_t b;
    b.action = act;
    b.count  = CountW'(n);
    b.set    = stamp_t'($urandom);
    b.set.year = YearW'($urandom);
    return b;
  endfunction

  // Mostly short steps; a handful of long ones.
  function automatic int step_count();
    if (big_left > 0 && $urandom_range(0, 24) == 0) begin
      big_left--;
      return $urandom_range(1024, 65535);
    end
    return $urandom_range(0, 1023);
  endfunction

  task automatic queue_directed();
    beat_t b;
    b.action = ACT_SPARE;
    b.count  = '1;
    b.set    = '1;
    pending_beats.push_back(b);                              // ignored code, all ones
    pending_beats.push_back(step_beat(ACT_BACK, 1));         // lower limit right after reset
    b.action = ACT_LOAD;
    pending_beats.push_back(b);                              // every load field at its top
    pending_beats.push_back(load_beat(0, 0, 0, 0, 0, 0));
    pending_beats.push_back(load_beat(2000, 13, 1, 0, 0, 0));
    pending_beats.push_back(load_beat(0, 6, 15, 12, 0, 0));
    pending_beats.push_back(load_beat(10000, 6, 15, 12, 0, 0));
    pending_beats.push_back(load_beat(2023, 2, 29, 0, 0, 0));
    pending_beats.push_back(load_beat(1900, 2, 29, 0, 0, 0));
    pending_beats.push_back(load_beat(2000, 2, 30, 0, 0, 0));
    pending_beats.push_back(load_beat(2024, 4, 0, 0, 0, 0));
    pending_beats.push_back(load_beat(2024, 4, 31, 24, 60, 60));   // date wins over time
    pending_beats.push_back(load_beat(2024, 4, 30, 24, 0, 0));
    pending_beats.push_back(load_beat(2024, 4, 30, 0, 60, 0));
    pending_beats.push_back(load_beat(2024, 4, 30, 31, 63, 63));
    pending_beats.push_back(load_beat(2000, 2, 29, 23, 59, 59));
    pending_beats.push_back(step_beat(ACT_FWD, 1));
    pending_beats.push_back(step_beat(ACT_BACK, 1));
    pending_beats.push_back(load_beat(YEAR_LAST, 12, 31, 23, 59, 50));
    pending_beats.push_back(step_beat(ACT_FWD, 20));
    pending_beats.push_back(step_beat(ACT_FWD, 0));
    pending_beats.push_back(load_beat(1, 1, 1, 0, 0, 5));
    pending_beats.push_back(step_beat(ACT_BACK, 10));
    pending_beats.push_back(load_beat(2023, 12, 31, 23, 59, 59));
    pending_beats.push_back(step_beat(ACT_FWD, 65535));
    pending_beats.push_back(step_beat(ACT_BACK, 65535));
  endtask

  task automatic queue_random(input int target);
    int made;
    int y, m, d, len;
    logic [1:0] act;
    made = 0;
    while (made < target) begin
      y   = $urandom_range(1, YEAR_LAST);
      m   = $urandom_range(1, 12);
      len = month_len(y, m);
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          // just before midnight, often at month or year end
          if ($urandom_range(0, 3) == 0) begin
            m = 12;
            d = 31;
          end else begin
            d = $urandom_range(0, 1) ? len : $urandom_range(1, len);
          end
          pending_beats.push_back(load_beat(y, m, d, 23, 59, $urandom_range(0, 59)));
          pending_beats.push_back(step_beat(ACT_FWD, step_count()));
          made += 2;
        end
        4, 5, 6, 7: begin
          // just after midnight, often on the first of a month or year
          if ($urandom_range(0, 3) == 0) m = 1;
          d = $urandom_range(0, 1) ? 1 : $urandom_range(1, len);
          pending_beats.push_back(load_beat(y, m, d, 0, 0, $urandom_range(0, 59)));
          pending_beats.push_back(step_beat(ACT_BACK, step_count()));
          made += 2;
        end
        8, 9: begin
          // around the end of February in leap and century years
          case ($urandom_range(0, 2))
            0:       y = 4 * $urandom_range(1, YEAR_LAST / 4);
            1:       y = 100 * $urandom_range(1, YEAR_LAST / 100);
            default: y = 400 * $urandom_range(1, YEAR_LAST / 400);
          endcase
          if ($urandom_range(0, 1)) begin
            pending_beats.push_back(load_beat(y, 2, 28, 23, 59, $urandom_range(0, 59)));
            pending_beats.push_back(step_beat(ACT_FWD, $urandom_range(1, 1023)));
          end else begin
            pending_beats.push_back(load_beat(y, 3, 1, 0, 0, $urandom_range(0, 59)));
            pending_beats.push_back(step_beat(ACT_BACK, $urandom_range(1, 1023)));
          end
          made += 2;
        end
        10, 11, 12: begin
          act = $urandom_range(0, 1) ? ACT_FWD : ACT_BACK;
          pending_beats.push_back(step_beat(act, step_count()));
          made += 1;
        end
        13, 14: begin
          pending_beats.push_back(load_beat(y, m, $urandom_range(1, len), $urandom_range(0, 23),
                                            $urandom_range(0, 59), $urandom_range(0, 59)));
          made += 1;
        end
        15, 16: begin
          // raw fields, mostly rejected
          pending_beats.push_back(load_beat($urandom_range(0, 16383), $urandom_range(0, 15),
                                            $urandom_range(0, 31), $urandom_range(0, 31),
                                            $urandom_range(0, 63), $urandom_range(0, 63)));
          made += 1;
        end
        17: begin
          pending_beats.push_back(step_beat(ACT_SPARE, $urandom_range(0, 65535)));
          made += 1;
        end
        default: begin
          if ($urandom_range(0, 1)) begin
            pending_beats.push_back(load_beat(YEAR_LAST, 12, 31, 23, 59, $urandom_range(0, 59)));
            pending_beats.push_back(step_beat(ACT_FWD, $urandom_range(0, 200)));
          end else begin
            pending_beats.push_back(load_beat(1, 1, 1, 0, $urandom_range(0, 2),
                                              $urandom_range(0, 59)));
            pending_beats.push_back(step_beat(ACT_BACK, $urandom_range(0, 300)));
          end
          made += 2;
        end
      endcase
    end
  endtask

  // ---------------- driver ----------------

  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_readings.push_back(apply_beat(drive_beat));
      end
      // hold a stalled beat; otherwise pick the next one or idle
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          drive_beat   = pending_beats.pop_front();
          in_valid_i   <= 1'b1;
          action_i     <= drive_beat.action;
          count_i      <= drive_beat.count;
          set_year_i   <= drive_beat.set.year;
          set_month_i  <= drive_beat.set.month;
          set_day_i    <= drive_beat.set.day;
          set_hour_i   <= drive_beat.set.hour;
          set_minute_i <= drive_beat.set.minute;
          set_second_i <= drive_beat.set.second;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 5);
            gap_left   = $urandom_range(0, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver stall ----------------

  stall_style_e stall_style = STALL_NONE;
  int           stall_span  = 0;
  logic [2:0]   pulse_phase = '0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_style = stall_style_e'($urandom_range(0, 3));
        stall_span  = $urandom_range(16, 128);
      end else begin
        stall_span--;
      end
      pulse_phase = pulse_phase + 1'b1;
      case (stall_style)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= (pulse_phase < 3'd3);
      endcase
    end
  end

  // ---------------- monitor ----------------

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_readings.size() == 0) begin
        $error("result beat with nothing expected: %0d-%0d-%0d %0d:%0d:%0d status %0d",
               cur_year_o, cur_month_o, cur_day_o, cur_hour_o, cur_minute_o,
               cur_second_o, status_o);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        n_checked++;
        check_field("cur_year",   want.now.year,   cur_year_o);
        check_field("cur_month",  want.now.month,  cur_month_o);
        check_field("cur_day",    want.now.day,    cur_day_o);
        check_field("cur_hour",   want.now.hour,   cur_hour_o);
        check_field("cur_minute", want.now.minute, cur_minute_o);
        check_field("cur_second", want.now.second, cur_second_o);
        check_field("status",     want.status,     status_o);
      end
    end
  end

  // ---------------- sequence and end of run ----------------

  initial begin
    model_now = '{year: 14'd1, month: 4'd1, day: 5'd1, hour: '0, minute: '0, second: '0};
    queue_directed();
    queue_random(74);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // sample between edges so the driver and monitor have settled
    while (pending_beats.size() != 0 || in_valid_i || expected_readings.size() != 0)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Checked %0d result beats: %0d loads (%0d rejected), %0d forward and %0d back steps",
             n_checked, n_loads, n_rejects, n_fwd, n_back);
    $display("Year-limit stops seen: %0d", n_limit);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d beats pending and %0d results outstanding",
             pending_beats.size(), expected_readings.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
rtl/cdc_pkg.sv
rtl/calendar_datetime_counter_top.sv
bench/tb_calendar_datetime_counter_top.sv
